>>> src/cfsd_pkg.sv
// Package for the CO2 sensor frame decoder.
// Holds the frame constants, the queue entry and word kind types, and the CRC-8 byte update.
// No dependencies.
package cfsd_pkg;

  localparam int POS_W      = 4;
  localparam int WORD_W     = 16;
  localparam int PROD_W     = 27;
  localparam int QUOT_W     = 11;
  localparam int THRESH_W   = 16;
  localparam int OUT_DATA_W = 48;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
  localparam logic [POS_W-1:0] POS_CO2_CRC  = 4'd2;
  localparam logic [POS_W-1:0] POS_TEMP_CRC = 4'd5;
  localparam logic [POS_W-1:0] POS_HUM_CRC  = 4'd8;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [WORD_W-1:0]   FULL_SCALE = 16'hFFFF;
  localparam logic [QUOT_W-1:0]   TEMP_SPAN  = 11'd1750;
  localparam logic [QUOT_W-1:0]   HUM_SPAN   = 11'd1000;
  localparam logic [PROD_W-1:0]   TEMP_OFF   = PROD_W'(450 * 65535);
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd100;

  typedef enum logic [1:0] {
    KIND_CO2,
    KIND_TEMP,
    KIND_HUM
  } word_kind_t;

  typedef struct packed {
    word_kind_t        kind;
    logic [WORD_W-1:0] word;
    logic              ok;
  } entry_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> src/co2_sensor_frame_decoder.sv
// Top level of the CO2 sensor frame decoder.
// Holds the threshold register and connects front end, queue and back end. Depends on cfsd_pkg.
//
// Bytes of a 9-byte measurement frame enter on the s_ channel, one item per byte, at up to
// one item per cycle; s_tuser high marks byte 0 of a new frame. A start mark in the middle
// of a frame restarts it; queued words remain. After byte 8 one result leaves on the m_ channel
// with the CO2 word, temperature and humidity in tenths, three CRC-ok flags and the CO2
// fast-change flag. Once the ninth byte is accepted, its word is written into the queue and
// then passes the product stage, the offset stage and the result register, where the result
// becomes valid.
// Throughput is one byte per cycle while s_tready is high, one result per nine bytes; the
// front end updates the CRC for each accepted byte.
// When the receiver stalls, the result register holds and the back end stops once the next
// result waits; the four-entry word queue then fills, and s_tready drops only when it is full.
// The cfg channel writes the CO2 jump threshold (reset 100 ppm) and is always ready; the user
// must write it only while no frame is in flight; the block does not enforce it. Synchronous
// reset clears frame position, CRC, the last good CO2 value and the output valid flag.
module co2_sensor_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] co2_ppm, [16] co2_ok, [28:17] temperature_tenths, [29] temperature_ok,
  // [39:30] humidity_tenths, [40] humidity_ok, [41] co2_fast_change, [47:42] zero
  output logic [47:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // [15:0] co2_jump_threshold
);

  logic [cfsd_pkg::THRESH_W-1:0] threshold;
  logic                          accept;
  logic                          push;
  cfsd_pkg::entry_t              push_entry;
  logic                          q_not_full;
  logic                          q_not_empty;
  logic                          q_pop;
  cfsd_pkg::entry_t              q_head;

  assign cfg_ready = 1'b1;
  assign s_tready  = q_not_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= cfsd_pkg::THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  cfsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (s_tdata),
    .frame_start (s_tuser),
    .push        (push),
    .push_entry  (push_entry)
  );

  cfsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  cfsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .threshold   (threshold),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

endmodule

>>> src/cfsd_front.sv
// Front end of the CO2 sensor frame decoder: byte position, running CRC and word assembly.
// Pushes one checked word per CRC byte into the queue. Depends on cfsd_pkg.
module cfsd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          rx_byte,
  input  logic                frame_start,
  output logic                push,
  output cfsd_pkg::entry_t    push_entry
);

  logic [cfsd_pkg::POS_W-1:0]  pos;
  logic [cfsd_pkg::POS_W-1:0]  pos_next;
  logic [cfsd_pkg::POS_W-1:0]  pos_eff;
  logic [7:0]                  crc;
  logic [7:0]                  crc_next;
  logic [7:0]                  crc_eff;
  logic [cfsd_pkg::WORD_W-1:0] word_bytes;
  logic                        is_crc_byte;

  always_comb begin
    pos_eff  = frame_start ? cfsd_pkg::POS_FIRST : pos;
    crc_eff  = frame_start ? cfsd_pkg::CRC_INIT : crc;
    is_crc_byte = pos_eff inside {cfsd_pkg::POS_CO2_CRC, cfsd_pkg::POS_TEMP_CRC,
                                  cfsd_pkg::POS_HUM_CRC};
    push_entry.word = word_bytes;
    push_entry.ok   = (crc_eff == rx_byte);
    case (pos_eff)
      cfsd_pkg::POS_CO2_CRC:  push_entry.kind = cfsd_pkg::KIND_CO2;
      cfsd_pkg::POS_TEMP_CRC: push_entry.kind = cfsd_pkg::KIND_TEMP;
      default:                push_entry.kind = cfsd_pkg::KIND_HUM;
    endcase
    push = accept && is_crc_byte;
    if (is_crc_byte) begin
      crc_next = cfsd_pkg::CRC_INIT;
    end else begin
      crc_next = cfsd_pkg::crc_feed(crc_eff, rx_byte);
    end
    // The frame wraps after the humidity CRC byte.
    if (pos_eff == cfsd_pkg::POS_HUM_CRC) begin
      pos_next = cfsd_pkg::POS_FIRST;
    end else begin
      pos_next = cfsd_pkg::POS_W'(pos_eff + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= cfsd_pkg::POS_FIRST;
      crc <= cfsd_pkg::CRC_INIT;
    end else if (accept) begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_crc_byte) begin
      word_bytes <= {word_bytes[7:0], rx_byte};
    end
  end

endmodule

>>> src/cfsd_queue.sv
// Short queue of checked words between the front and back ends of the frame decoder.
// Depends on cfsd_pkg.
module cfsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cfsd_pkg::entry_t push_entry,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output cfsd_pkg::entry_t head
);

  cfsd_pkg::entry_t                 slots [cfsd_pkg::Q_DEPTH];
  logic [cfsd_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [cfsd_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [cfsd_pkg::Q_CNT_W-1:0]     count;
  logic                             do_push;
  logic                             do_pop;

  assign not_full  = (count != cfsd_pkg::Q_CNT_W'(cfsd_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= cfsd_pkg::Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= cfsd_pkg::Q_PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= cfsd_pkg::Q_CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= cfsd_pkg::Q_CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> src/cfsd_back.sv
// Back end of the frame decoder: fast-change check, scaling pipeline and result register.
// Takes checked words from the queue. Depends on cfsd_pkg.
module cfsd_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [cfsd_pkg::THRESH_W-1:0]       threshold,
  input  logic                                q_not_empty,
  input  cfsd_pkg::entry_t                    q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [cfsd_pkg::OUT_DATA_W-1:0]     out_data
);

  // Stage A: product and fast-change flag.
  logic                          a_valid;
  cfsd_pkg::word_kind_t          a_kind;
  logic                          a_ok;
  logic [cfsd_pkg::WORD_W-1:0]   a_word;
  logic                          a_fast;
  logic [cfsd_pkg::PROD_W-1:0]   a_prod;
  // Stage B: magnitude of the scaled numerator and its sign.
  logic                          b_valid;
  cfsd_pkg::word_kind_t          b_kind;
  logic                          b_ok;
  logic [cfsd_pkg::WORD_W-1:0]   b_word;
  logic                          b_fast;
  logic [cfsd_pkg::PROD_W-1:0]   b_mag;
  logic                          b_neg;

  logic [cfsd_pkg::WORD_W-1:0]   last_valid_co2;
  logic                          last_co2_present;
  logic [cfsd_pkg::WORD_W-1:0]   held_co2;
  logic [11:0]                   held_temperature;
  logic [2:0]                    held_ok_flags;
  logic                          held_fast;

  logic                          advance;
  logic                          emit;
  logic [cfsd_pkg::QUOT_W-1:0]   scale;
  logic [cfsd_pkg::PROD_W-1:0]   prod;
  logic [cfsd_pkg::WORD_W:0]     co2_diff;
  logic [cfsd_pkg::WORD_W-1:0]   co2_mag;
  logic                          fast_now;
  logic [cfsd_pkg::QUOT_W-1:0]   q0;
  logic [cfsd_pkg::WORD_W:0]     r0;
  logic [cfsd_pkg::QUOT_W-1:0]   quot;
  logic [11:0]                   quot_ext;
  logic [11:0]                   temp_val;
  logic [9:0]                    hum_val;

  assign emit    = b_valid && (b_kind == cfsd_pkg::KIND_HUM);
  // The pipeline only holds when a finished result has nowhere to go.
  assign advance = !(emit && out_valid && !out_ready);
  assign q_pop   = advance;

  always_comb begin
    case (q_head.kind)
      cfsd_pkg::KIND_TEMP: scale = cfsd_pkg::TEMP_SPAN;
      default:             scale = cfsd_pkg::HUM_SPAN;
    endcase
    prod     = cfsd_pkg::PROD_W'(q_head.word) * cfsd_pkg::PROD_W'(scale);
    co2_diff = {1'b0, q_head.word} - {1'b0, last_valid_co2};
    co2_mag  = co2_diff[cfsd_pkg::WORD_W] ? (last_valid_co2 - q_head.word)
                                          : co2_diff[cfsd_pkg::WORD_W-1:0];
    fast_now = last_co2_present && (co2_mag >= threshold);

    // Divide by 65535: the high half underestimates by at most one.
    q0       = b_mag[cfsd_pkg::PROD_W-1:16];
    r0       = {1'b0, b_mag[15:0]} + (cfsd_pkg::WORD_W+1)'(q0);
    quot     = cfsd_pkg::QUOT_W'(q0 + cfsd_pkg::QUOT_W'(r0 >= {1'b0, cfsd_pkg::FULL_SCALE}));
    quot_ext = {1'b0, quot};
    temp_val = b_neg ? (~quot_ext + 12'd1) : quot_ext;
    hum_val  = quot[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid          <= 1'b0;
      b_valid          <= 1'b0;
      last_co2_present <= 1'b0;
      last_valid_co2   <= '0;
      held_ok_flags    <= '0;
      held_fast        <= 1'b0;
      out_valid        <= 1'b0;
    end else if (advance) begin
      a_valid <= q_not_empty;
      b_valid <= a_valid;
      if (q_not_empty && q_head.kind == cfsd_pkg::KIND_CO2 && q_head.ok) begin
        last_valid_co2   <= q_head.word;
        last_co2_present <= 1'b1;
      end
      if (b_valid) begin
        case (b_kind)
          cfsd_pkg::KIND_CO2: begin
            held_ok_flags <= {2'b00, b_ok};
            held_fast     <= b_fast;
          end
          cfsd_pkg::KIND_TEMP: held_ok_flags[1] <= b_ok;
          default:             held_ok_flags    <= held_ok_flags;
        endcase
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_kind <= q_head.kind;
      a_ok   <= q_head.ok;
      a_word <= q_head.word;
      a_fast <= (q_head.kind == cfsd_pkg::KIND_CO2) && q_head.ok && fast_now;
      a_prod <= prod;
      b_kind <= a_kind;
      b_ok   <= a_ok;
      b_word <= a_word;
      b_fast <= a_fast;
      if (a_kind == cfsd_pkg::KIND_TEMP) begin
        b_neg <= (a_prod < cfsd_pkg::TEMP_OFF);
        b_mag <= (a_prod < cfsd_pkg::TEMP_OFF) ? (cfsd_pkg::TEMP_OFF - a_prod)
                                               : (a_prod - cfsd_pkg::TEMP_OFF);
      end else begin
        b_neg <= 1'b0;
        b_mag <= a_prod;
      end
      if (b_valid && b_kind == cfsd_pkg::KIND_CO2) begin
        held_co2 <= b_ok ? b_word : '0;
      end
      if (b_valid && b_kind == cfsd_pkg::KIND_TEMP) begin
        held_temperature <= b_ok ? temp_val : '0;
      end
      if (emit) begin
        out_data <= {6'd0, held_fast, b_ok, (b_ok ? hum_val : 10'd0), held_ok_flags[1],
                     held_temperature, held_ok_flags[0], held_co2};
      end
    end
  end

endmodule
